// ----- hw/rtl/ttg_pkg.sv -----
// ----------------------------------------------------------------------------
// ttg_pkg
// Shared types and constants of the triangle tangent generator.
// ----------------------------------------------------------------------------
package ttg_pkg;

  // Default number of fraction bits of the position and UV inputs.
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Configuration register byte addresses.
  localparam logic [2:0] ADDR_UV_PRESENT    = 3'd0;
  localparam logic [2:0] ADDR_SHORT_INDICES = 3'd4;

  // Width of the shared multiplier operands and of its accumulator.
  localparam int unsigned MUL_W = 34;
  localparam int unsigned ACC_W = 70;

  // Width of the tangent magnitudes before normalization.
  localparam int unsigned MAG_W = 68;

  // Quotient bits of one Q1.15 division and width of the vector length.
  localparam int unsigned QUOT_W = 17;
  localparam int unsigned LEN_W  = 31;

  typedef enum logic [1:0] {
    MAC_HOLD,
    MAC_LOAD,
    MAC_ADD,
    MAC_SUB
  } mac_op_t;

  typedef struct packed {
    mac_op_t op;
  } mac_ctl_t;

  typedef enum logic [2:0] {
    RD_IDLE,
    RD_ROOT_INIT,
    RD_ROOT_STEP,
    RD_DIV_INIT,
    RD_DIV_STEP
  } rd_op_t;

  typedef struct packed {
    rd_op_t op;
  } rd_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CROSS,
    ST_TAN,
    ST_NORM,
    ST_SQ,
    ST_ROOT,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// ----- hw/rtl/ttg_mac.sv -----
// ----------------------------------------------------------------------------
// ttg_mac
// Shared signed multiplier with a registered product and a wide accumulator.
// ----------------------------------------------------------------------------
module ttg_mac (
  input  logic                                 clk,
  input  ttg_pkg::mac_ctl_t                    ctl,
  input  logic signed [ttg_pkg::MUL_W-1:0]     a,
  input  logic signed [ttg_pkg::MUL_W-1:0]     b,
  output logic signed [ttg_pkg::ACC_W-1:0]     acc
);
  import ttg_pkg::*;

  logic signed [2*MUL_W-1:0] prod;

  // The product of one cycle is folded into the accumulator in the next.
  always_ff @(posedge clk) begin
    prod <= a * b;
    unique case (ctl.op)
      MAC_HOLD: acc <= acc;
      MAC_LOAD: acc <= ACC_W'(prod);
      MAC_ADD:  acc <= acc + ACC_W'(prod);
      MAC_SUB:  acc <= acc - ACC_W'(prod);
      default:  acc <= acc;
    endcase
  end

endmodule

// ----- hw/rtl/ttg_root_div.sv -----
// ----------------------------------------------------------------------------
// ttg_root_div
// Bit-serial integer square root and restoring divider, one bit a cycle.
// ----------------------------------------------------------------------------
module ttg_root_div (
  input  logic                              clk,
  input  ttg_pkg::rd_ctl_t                  ctl,
  input  logic [61:0]                       sumsq,
  input  logic [29:0]                       comp,
  output logic [ttg_pkg::LEN_W-1:0]         len,
  output logic [ttg_pkg::QUOT_W-1:0]        quot
);
  import ttg_pkg::*;

  logic [61:0]        rem_sq;
  logic [63:0]        res;
  logic [62:0]        bitv;
  logic [63:0]        trial;
  logic [LEN_W-1:0]   rem;
  logic [QUOT_W-1:0]  low;
  logic [45:0]        num;
  logic [LEN_W:0]     dtrial;

  assign len    = res[LEN_W-1:0];
  assign trial  = res + 64'(bitv);
  assign num    = {1'b0, comp, 15'd0} + 46'(len >> 1);
  assign dtrial = {rem, low[QUOT_W-1]};

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      RD_IDLE: begin
      end
      RD_ROOT_INIT: begin
        rem_sq <= sumsq;
        res    <= '0;
        bitv   <= 63'd1 << 62;
      end
      RD_ROOT_STEP: begin
        if (64'(rem_sq) >= trial) begin
          rem_sq <= rem_sq - trial[61:0];
          res    <= (res >> 1) + 64'(bitv);
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
      end
      RD_DIV_INIT: begin
        // The numerator is below len * 2^17, so its upper part starts below len.
        rem  <= LEN_W'(num[45:QUOT_W]);
        low  <= num[QUOT_W-1:0];
        quot <= '0;
      end
      RD_DIV_STEP: begin
        if (dtrial >= {1'b0, len}) begin
          rem  <= LEN_W'(dtrial - {1'b0, len});
          quot <= {quot[QUOT_W-2:0], 1'b1};
        end else begin
          rem  <= dtrial[LEN_W-1:0];
          quot <= {quot[QUOT_W-2:0], 1'b0};
        end
        low <= low << 1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/triangle_tangent_generator_unit.sv -----
// ----------------------------------------------------------------------------
// triangle_tangent_generator_unit
// Per-triangle tangent from positions and UVs, sent once per corner index.
// ----------------------------------------------------------------------------
// Vertices arrive one request at a time on the slave stream. The first two
// corners of a triangle are stored and the port stays ready. The third
// corner starts the computation and the port is not ready until all three
// results of that triangle have been taken. The work runs on one shared
// 34x34 multiplier with a 70-bit accumulator: the UV cross product (skipped
// when the default UV triangle is already chosen on arrival), the three
// tangent components and the sum of squares. A right-shift normalize then
// shifts the magnitudes by at most 35 bits, followed by a bit-serial square
// root and a restoring divider per component; the divider is skipped when
// the tangent is zero. Results leave as three requests on the master
// stream, tlast marking the third, tuser carrying the duplicate-index flag.
// Configuration is to be written over the APB port only while idle; the
// block itself does not enforce this.

module triangle_tangent_generator_unit #(
  parameter int unsigned FRAC_BITS = ttg_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // APB configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // Vertex stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vertex_index[31:0], pos_x[63:32], pos_y[95:64], pos_z[127:96],
  // tex_u[159:128], tex_v[191:160]
  input  logic [191:0] s_axis_tdata,
  // Tangent stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_index[31:0], tangent_x[47:32], tangent_y[63:48], tangent_z[79:64]
  output logic [79:0]  m_axis_tdata,
  // degenerate[0]
  output logic         m_axis_tuser,
  output logic         m_axis_tlast
);
  import ttg_pkg::*;

  localparam logic signed [32:0] ONE     = 33'sd1 <<< FRAC_BITS;
  localparam logic signed [33:0] NEG_ONE = -(34'sd1 <<< FRAC_BITS);

  // Configuration registers.
  logic uv_present;
  logic short_indices;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      uv_present    <= 1'b0;
      short_indices <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr == ADDR_UV_PRESENT) begin
        uv_present <= pwdata[0];
      end
      if (paddr == ADDR_SHORT_INDICES) begin
        short_indices <= pwdata[0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_UV_PRESENT) begin
      prdata = {31'd0, uv_present};
    end else if (paddr == ADDR_SHORT_INDICES) begin
      prdata = {31'd0, short_indices};
    end
  end

  // Input field unpacking; v is flipped to 1 - v on arrival.
  logic        [31:0] in_index;
  logic signed [31:0] in_pos [3];
  logic signed [32:0] in_u;
  logic signed [32:0] in_v;

  assign in_index  = short_indices ? {16'd0, s_axis_tdata[15:0]} : s_axis_tdata[31:0];
  assign in_pos[0] = s_axis_tdata[63:32];
  assign in_pos[1] = s_axis_tdata[95:64];
  assign in_pos[2] = s_axis_tdata[127:96];
  assign in_u      = 33'(signed'(s_axis_tdata[159:128]));
  assign in_v      = ONE - 33'(signed'(s_axis_tdata[191:160]));

  // Sequencer registers.
  state_t     state, state_next;
  logic [5:0] step, step_next;
  logic [1:0] comp, comp_next;
  logic [1:0] corner_count;

  // Held corners and per-triangle data.
  logic        [31:0] idx0, idx1, idx2;
  logic signed [31:0] pos0 [3];
  logic signed [31:0] pos1 [3];
  logic signed [32:0] u0, v0, u1, v1;
  logic signed [32:0] d1 [3];
  logic signed [32:0] d2 [3];
  logic signed [33:0] du1x, du1y, du2x, du2y;
  logic               cross_neg;
  logic               degen;
  logic        [MAG_W-1:0] mag [3];
  logic               neg [3];
  logic        [15:0] tq [3];

  // Shared units.
  mac_ctl_t                  mac_ctl;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [ACC_W-1:0]   acc;
  rd_ctl_t                   rd_ctl;
  logic        [LEN_W-1:0]   len;
  logic        [QUOT_W-1:0]  quot;

  ttg_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mul_a),
    .b   (mul_b),
    .acc (acc)
  );

  ttg_root_div u_root_div (
    .clk   (clk),
    .ctl   (rd_ctl),
    .sumsq (acc[61:0]),
    .comp  (mag[comp][29:0]),
    .len   (len),
    .quot  (quot)
  );

  logic accept;
  logic third;
  logic uv_eq;
  logic def_pre;
  logic any_big;
  logic [1:0] tan_sel;
  logic [1:0] cap_sel;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign third         = (corner_count == 2'd2);
  assign uv_eq         = (u0 == u1 && v0 == v1) || (u0 == in_u && v0 == in_v) ||
                         (in_u == u1 && in_v == v1);
  assign def_pre       = !uv_present || uv_eq;
  assign any_big       = (|mag[0][MAG_W-1:30]) || (|mag[1][MAG_W-1:30]) ||
                         (|mag[2][MAG_W-1:30]);
  assign tan_sel       = step[2:1];
  assign cap_sel       = step[2:1] - 2'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      comp  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      comp  <= comp_next;
    end
  end

  // Next state, step counter and the controls of the shared units.
  always_comb begin
    state_next = state;
    step_next  = step + 6'd1;
    comp_next  = comp;
    mac_ctl.op = MAC_HOLD;
    rd_ctl.op  = RD_IDLE;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      ST_IDLE: begin
        step_next = '0;
        comp_next = '0;
        if (accept && third) begin
          state_next = def_pre ? ST_TAN : ST_CROSS;
        end
      end
      ST_CROSS: begin
        if (step == 6'd0) begin
          mul_a = du1x;
          mul_b = du2y;
        end else if (step == 6'd1) begin
          mul_a      = du1y;
          mul_b      = du2x;
          mac_ctl.op = MAC_LOAD;
        end else if (step == 6'd2) begin
          mac_ctl.op = MAC_SUB;
        end else begin
          state_next = ST_TAN;
          step_next  = '0;
        end
      end
      ST_TAN: begin
        if (step < 6'd6) begin
          mul_a = step[0] ? MUL_W'(d2[tan_sel]) : MUL_W'(d1[tan_sel]);
          mul_b = step[0] ? du1y : du2y;
        end
        if (step[0] && step <= 6'd5) begin
          mac_ctl.op = MAC_LOAD;
        end else if (!step[0] && step >= 6'd2 && step <= 6'd6) begin
          mac_ctl.op = MAC_SUB;
        end
        if (step == 6'd7) begin
          state_next = ST_NORM;
          step_next  = '0;
        end
      end
      ST_NORM: begin
        step_next = '0;
        if (!any_big) begin
          state_next = ST_SQ;
        end
      end
      ST_SQ: begin
        if (step < 6'd3) begin
          mul_a = MUL_W'(mag[step[1:0]][29:0]);
          mul_b = MUL_W'(mag[step[1:0]][29:0]);
        end
        if (step == 6'd1) begin
          mac_ctl.op = MAC_LOAD;
        end else if (step == 6'd2 || step == 6'd3) begin
          mac_ctl.op = MAC_ADD;
        end else if (step == 6'd4) begin
          rd_ctl.op  = RD_ROOT_INIT;
          state_next = ST_ROOT;
          step_next  = '0;
        end
      end
      ST_ROOT: begin
        rd_ctl.op = RD_ROOT_STEP;
        if (step == 6'd31) begin
          state_next = ST_DIV;
          step_next  = '0;
          comp_next  = '0;
        end
      end
      ST_DIV: begin
        if (step == 6'd0) begin
          if (len == '0) begin
            state_next = ST_OUT;
            step_next  = '0;
            comp_next  = '0;
          end else begin
            rd_ctl.op = RD_DIV_INIT;
          end
        end else if (step <= 6'(QUOT_W)) begin
          rd_ctl.op = RD_DIV_STEP;
        end else begin
          step_next = '0;
          if (comp == 2'd2) begin
            state_next = ST_OUT;
            comp_next  = '0;
          end else begin
            comp_next = comp + 2'd1;
          end
        end
      end
      ST_OUT: begin
        step_next = '0;
        if (m_axis_tready) begin
          if (comp == 2'd2) begin
            state_next = ST_IDLE;
            comp_next  = '0;
          end else begin
            comp_next = comp + 2'd1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Corner counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      corner_count <= '0;
    end else if (accept) begin
      corner_count <= third ? 2'd0 : corner_count + 2'd1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (corner_count == 2'd0) begin
        idx0 <= in_index;
        pos0 <= in_pos;
        u0   <= in_u;
        v0   <= in_v;
      end else if (corner_count == 2'd1) begin
        idx1 <= in_index;
        pos1 <= in_pos;
        u1   <= in_u;
        v1   <= in_v;
      end else begin
        idx2      <= in_index;
        degen     <= (idx0 == idx1) || (idx1 == in_index) || (in_index == idx0);
        cross_neg <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          d1[i] <= 33'(pos1[i]) - 33'(pos0[i]);
          d2[i] <= 33'(in_pos[i]) - 33'(pos0[i]);
        end
        if (def_pre) begin
          du1x <= NEG_ONE;
          du1y <= '0;
          du2x <= '0;
          du2y <= NEG_ONE;
        end else begin
          du1x <= 34'(u1) - 34'(u0);
          du1y <= 34'(v1) - 34'(v0);
          du2x <= 34'(in_u) - 34'(u0);
          du2y <= 34'(in_v) - 34'(v0);
        end
      end
    end

    // A zero UV cross product falls back to the default UV triangle.
    if (state == ST_CROSS && step == 6'd3) begin
      if (acc == '0) begin
        cross_neg <= 1'b0;
        du1x      <= NEG_ONE;
        du1y      <= '0;
        du2x      <= '0;
        du2y      <= NEG_ONE;
      end else begin
        cross_neg <= acc[ACC_W-1];
      end
    end

    if (state == ST_TAN && (step == 6'd3 || step == 6'd5 || step == 6'd7)) begin
      mag[cap_sel] <= acc[ACC_W-1] ? MAG_W'(-acc) : MAG_W'(acc);
      neg[cap_sel] <= (acc != '0) && (acc[ACC_W-1] ^ cross_neg);
    end

    if (state == ST_NORM && any_big) begin
      for (int i = 0; i < 3; i++) begin
        mag[i] <= mag[i] >> 1;
      end
    end

    if (state == ST_DIV) begin
      if (step == 6'd0 && len == '0) begin
        tq[0] <= 16'h7FFF;
        tq[1] <= '0;
        tq[2] <= '0;
      end else if (step == 6'(QUOT_W + 1)) begin
        if (!neg[comp]) begin
          tq[comp] <= (quot > QUOT_W'(32767)) ? 16'h7FFF : quot[15:0];
        end else if (quot > QUOT_W'(32768)) begin
          tq[comp] <= 16'h8000;
        end else begin
          tq[comp] <= 16'(QUOT_W'(0) - quot);
        end
      end
    end
  end

  // Result stream, one corner per request.
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tuser  = degen;
  assign m_axis_tlast  = (comp == 2'd2);

  always_comb begin
    unique case (comp)
      2'd0:    m_axis_tdata = {tq[2], tq[1], tq[0], idx0};
      2'd1:    m_axis_tdata = {tq[2], tq[1], tq[0], idx1};
      default: m_axis_tdata = {tq[2], tq[1], tq[0], idx2};
    endcase
  end

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking regression of the triangle tangent generator.
// ----------------------------------------------------------------------------
// Vertices are sent as requests on the slave stream. A local tangent predictor
// keeps its own copy of the held corners and registers and, on every third
// corner, queues the three expected tangent requests. A monitor compares each
// accepted tangent request field by field with the oldest expectation. Both
// streams idle at random, except during one long stretch with no idling.

module tb_top;
  import ttg_pkg::*;

  localparam int ONE = 1 << FRAC_BITS_DEF;
  localparam int LIMIT = 2000000;
  localparam int DRAIN = 400;

  typedef struct packed {
    logic [31:0] idx;
    logic [15:0] tx;
    logic [15:0] ty;
    logic [15:0] tz;
    logic        degen;
    logic        last;
  } tangent_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [79:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;

  // Predictor state.
  logic        uv_on, short_on;
  int          corners;
  logic [31:0] kept_idx [2];
  longint      kept_pos [6];
  longint      kept_uv  [4];

  tangent_t    tangent_q[$];
  int          errors = 0;
  int          cycles = 0;
  bit          calm = 1'b0;   // no idling while set

  triangle_tangent_generator_unit u_dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("triangle_tangent_generator_unit regression: fail");
      $finish;
    end
  end

  // Sink side: random stalls.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 21);
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    tangent_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[47:32], m_axis_tdata[63:48],
             m_axis_tdata[79:64], m_axis_tuser, m_axis_tlast};
      if (tangent_q.size() == 0) begin
        $display("%0t: unexpected tangent request %h", $time, got);
        errors++;
      end else begin
        want = tangent_q.pop_front();
        if (got.idx !== want.idx) begin
          $display("%0t: index exp %h got %h", $time, want.idx, got.idx);
          errors++;
        end
        if (got.tx !== want.tx) begin
          $display("%0t: tangent_x exp %h got %h", $time, want.tx, got.tx);
          errors++;
        end
        if (got.ty !== want.ty) begin
          $display("%0t: tangent_y exp %h got %h", $time, want.ty, got.ty);
          errors++;
        end
        if (got.tz !== want.tz) begin
          $display("%0t: tangent_z exp %h got %h", $time, want.tz, got.tz);
          errors++;
        end
        if (got.degen !== want.degen) begin
          $display("%0t: degenerate exp %b got %b", $time, want.degen, got.degen);
          errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last exp %b got %b", $time, want.last, got.last);
          errors++;
        end
      end
    end
  end

  // Rounded Q1.15 quotient, saturated.
  function automatic logic [15:0] q15_of(longint unsigned mag, bit neg, longint unsigned len);
    longint unsigned q;
    q = (mag * 32768 + len / 2) / len;
    if (!neg) return (q > 32767) ? 16'h7fff : q[15:0];
    if (q > 32768) q = 32768;
    return 16'(-q);
  endfunction

  function automatic longint unsigned root_of(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Tangent predictor: consumes one corner, queues three results on the third.
  task automatic predict_tangent(logic [31:0] vi_in, longint px, longint py, longint pz,
                                 longint tu, longint tv_raw);
    logic [31:0]            vi;
    logic [31:0]            ix [3];
    longint                 p [9];
    longint                 uv [6];
    longint                 d1x, d1y, d2x, d2y, a, b;
    logic signed [129:0]    crs;
    logic signed [129:0]    t [3];
    logic [129:0]           m [3];
    bit                     ng [3];
    bit                     dflt, dg;
    int                     maxbl, sh;
    longint unsigned        c [3], len;
    logic [15:0]            ox, oy, oz;
    tangent_t               e;
    vi = short_on ? {16'h0, vi_in[15:0]} : vi_in;
    if (corners < 2) begin
      kept_idx[corners] = vi;
      kept_pos[corners*3] = px;
      kept_pos[corners*3+1] = py;
      kept_pos[corners*3+2] = pz;
      kept_uv[corners*2] = tu;
      kept_uv[corners*2+1] = ONE - tv_raw;
      corners++;
      return;
    end
    corners = 0;
    ix[0] = kept_idx[0]; ix[1] = kept_idx[1]; ix[2] = vi;
    for (int i = 0; i < 6; i++) p[i] = kept_pos[i];
    p[6] = px; p[7] = py; p[8] = pz;
    for (int i = 0; i < 4; i++) uv[i] = kept_uv[i];
    uv[4] = tu; uv[5] = ONE - tv_raw;
    dg = (ix[0] == ix[1]) || (ix[1] == ix[2]) || (ix[0] == ix[2]);
    dflt = !uv_on;
    if (!dflt && ((uv[0] == uv[2] && uv[1] == uv[3]) || (uv[0] == uv[4] && uv[1] == uv[5])
        || (uv[4] == uv[2] && uv[5] == uv[3]))) dflt = 1'b1;
    for (int k = 0; k < 2; k++) begin
      if (dflt) begin
        uv[0] = ONE; uv[1] = ONE; uv[2] = 0; uv[3] = ONE; uv[4] = ONE; uv[5] = 0;
      end
      d1x = uv[2] - uv[0]; d1y = uv[3] - uv[1];
      d2x = uv[4] - uv[0]; d2y = uv[5] - uv[1];
      crs = 130'(d1x) * 130'(d2y) - 130'(d1y) * 130'(d2x);
      if (crs != 0 || dflt) break;
      dflt = 1'b1;
    end
    maxbl = 0;
    for (int i = 0; i < 3; i++) begin
      a = p[3+i] - p[i];
      b = p[6+i] - p[i];
      t[i] = 130'(a) * 130'(d2y) - 130'(b) * 130'(d1y);
      if (crs < 0) t[i] = -t[i];
      ng[i] = t[i] < 0;
      m[i] = ng[i] ? -t[i] : t[i];
      for (int j = 129; j >= 0; j--)
        if (m[i][j]) begin
          if (j + 1 > maxbl) maxbl = j + 1;
          break;
        end
    end
    sh = (maxbl > 30) ? maxbl - 30 : 0;
    for (int i = 0; i < 3; i++) c[i] = 64'(m[i] >> sh);
    len = root_of(c[0]*c[0] + c[1]*c[1] + c[2]*c[2]);
    if (len == 0) begin
      ox = 16'h7fff; oy = '0; oz = '0;
    end else begin
      ox = q15_of(c[0], ng[0], len);
      oy = q15_of(c[1], ng[1], len);
      oz = q15_of(c[2], ng[2], len);
    end
    for (int k = 0; k < 3; k++) begin
      e = {ix[k], ox, oy, oz, dg, k == 2};
      tangent_q.insert(tangent_q.size(), e);
    end
  endtask

  // Sends one vertex request, idling at random first, and predicts it.
  // tvalid stays high after the handshake; the next request or an idle cycle
  // takes it over, so back-to-back requests need no gap.
  task automatic send_vertex(logic [31:0] vi, logic [31:0] px, logic [31:0] py,
                             logic [31:0] pz, logic [31:0] tu, logic [31:0] tv);
    while (!calm && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tv, tu, pz, py, px, vi};
    do @(posedge clk); while (!s_axis_tready);
    predict_tangent(vi, longint'($signed(px)), longint'($signed(py)), longint'($signed(pz)),
                    longint'($signed(tu)), longint'($signed(tv)));
  endtask

  // Register write while idle: waits for all results plus a settle margin.
  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    s_axis_tvalid <= 1'b0;
    while (tangent_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_UV_PRESENT) uv_on = value[0];
    else short_on = value[0];
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(8*ONE)) - 4*ONE);
      2: return 32'($urandom_range(3) * ONE);
      default: return {{16{$urandom_range(1) == 1}}, 16'($urandom())};
    endcase
  endfunction

  task automatic test_directed();
    // Extremes of position and UV, default UV, duplicates and a zero tangent.
    send_vertex(32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0, 32'h0);
    send_vertex(32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h0);
    send_vertex(32'h1234_5678, 32'h0, 32'h0, 32'h7fff_ffff, 32'h0, 32'h8000_0000);
    // All positions equal: zero tangent.
    repeat (3) send_vertex(32'd7, ONE, ONE, ONE, 0, 0);
    write_reg(ADDR_UV_PRESENT, 32'd1);
    // Real UVs.
    send_vertex(32'd1, 0, 0, 0, 0, 0);
    send_vertex(32'd2, ONE, 0, 0, ONE, 0);
    send_vertex(32'd3, 0, ONE, 0, 0, ONE);
    // Coinciding UV corners fall back to the default triangle.
    send_vertex(32'd4, 0, 0, 0, ONE, ONE);
    send_vertex(32'd5, ONE, 2*ONE, 0, ONE, ONE);
    send_vertex(32'd6, 0, ONE, 3*ONE, 0, 0);
    // Collinear UVs: zero cross product.
    send_vertex(32'd8, 0, 0, 0, 0, 0);
    send_vertex(32'd9, ONE, 0, ONE, ONE, ONE);
    send_vertex(32'd10, 0, ONE, 0, 2*ONE, 2*ONE);
    // Extreme UVs, mirrored orientation.
    send_vertex(32'h8000_0000, 32'h8000_0000, 0, 0, 32'h8000_0000, 32'h7fff_ffff);
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0, 32'h7fff_ffff, 32'h8000_0000);
    send_vertex(32'h0001_8000, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    write_reg(ADDR_SHORT_INDICES, 32'd1);
    // Indices that collide only after masking to 16 bits.
    send_vertex(32'hABCD_0001, ONE, 0, 0, 0, 0);
    send_vertex(32'h1234_0001, 0, ONE, 0, ONE, 0);
    send_vertex(32'hffff_ffff, 0, 0, ONE, 0, ONE);
  endtask

  task automatic test_random(int tris);
    logic [31:0] base;
    for (int n = 0; n < tris; n++) begin
      // Phase boundaries switch the registers, extremes included.
      if (n % 35 == 0) begin
        write_reg(ADDR_UV_PRESENT, 32'($urandom_range(1)));
        write_reg(ADDR_SHORT_INDICES, 32'($urandom_range(1)));
      end
      calm = (n >= 60 && n < 80);
      base = ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom();
      for (int k = 0; k < 3; k++)
        send_vertex(($urandom_range(5) == 0) ? base : $urandom(), rnd_coord(), rnd_coord(),
                    rnd_coord(), rnd_coord(), rnd_coord());
    end
    calm = 1'b0;
  endtask

  initial begin
    uv_on = 1'b0;
    short_on = 1'b0;
    corners = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(133);
    s_axis_tvalid <= 1'b0;
    while (tangent_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("triangle_tangent_generator_unit regression: pass");
    end else begin
      $display("triangle_tangent_generator_unit regression: fail");
    end
    $finish;
  end

endmodule
